>>> hdl/i2cms_pkg.sv
// Package for the I2C master transfer sequencer.
// Holds item codes, phase and sequencer state types, register values and the
// command and status structs shared by the controller and the datapath.
package i2cms_pkg;

  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam int BYTE_W = 8;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_BUSY = 2'd1;
  localparam logic [1:0] ERR_IDLE = 2'd2;

  localparam logic [7:0] CTL_START_TX = 8'hb0;
  localparam logic [7:0] CTL_START_RX = 8'ha0;
  localparam logic [7:0] CTL_TXAK     = 8'ha8;
  localparam logic [7:0] CTL_STOP     = 8'h80;
  localparam logic [7:0] CTL_IE       = 8'h40;
  localparam logic [7:0] ST_NOACK     = 8'h01;
  localparam logic [7:0] ST_ARBL      = 8'h10;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ADDR,
    PH_TX,
    PH_RX
  } phase_t;

  typedef enum logic {
    SEQ_WAIT,
    SEQ_EXEC
  } seq_t;

  typedef enum logic [2:0] {
    CSEL_NONE,
    CSEL_START_TX,
    CSEL_START_RX,
    CSEL_START_RX_AK,
    CSEL_TXAK,
    CSEL_STOP
  } ctrl_sel_t;

  typedef enum logic [1:0] {
    DSEL_NONE,
    DSEL_ADDR,
    DSEL_BUF
  } data_sel_t;

  typedef enum logic [1:0] {
    POS_HOLD,
    POS_CLEAR,
    POS_ONE,
    POS_INC
  } pos_op_t;

  typedef struct packed {
    logic      capture;
    logic      commit;
    logic      save_start;
    pos_op_t   pos_op;
    ctrl_sel_t ctrl_sel;
    data_sel_t data_sel;
    logic      rx_deliver;
    logic      done;
    logic      resp;
    logic [1:0] err;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       ack_ok;
    logic       noack;
    logic       read_flag;
    logic       count_one;
    logic       tx_more;
    logic       rx_penult;
    logic       rx_last;
    logic       out_free;
  } dp_status_t;

endpackage

>>> hdl/i2cms_cfg_if.sv
// Configuration write channel of the I2C master transfer sequencer.
// Carries the interrupt enable register value; no other dependencies.
interface i2cms_cfg_if;
  logic valid;
  logic ready;
  logic int_enable;

  modport source (output valid, output int_enable, input ready);
  modport sink (input valid, input int_enable, output ready);
endinterface

>>> hdl/i2cms_req_if.sv
// Input item channel of the I2C master transfer sequencer.
// Carries load, start and controller event items; no other dependencies.
interface i2cms_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] tx_index;
  logic [7:0] tx_byte;
  logic [7:0] address_byte;
  logic [4:0] byte_count;
  logic [7:0] status_flags;
  logic [7:0] rx_data;

  modport source (output valid, output kind, output tx_index, output tx_byte,
                  output address_byte, output byte_count, output status_flags,
                  output rx_data, input ready);
  modport sink (input valid, input kind, input tx_index, input tx_byte,
                input address_byte, input byte_count, input status_flags,
                input rx_data, output ready);
endinterface

>>> hdl/i2cms_rsp_if.sv
// Result channel of the I2C master transfer sequencer.
// Carries controller register writes, received bytes and done/error codes.
interface i2cms_rsp_if;
  logic       valid;
  logic       ready;
  logic       ctrl_write;
  logic [7:0] ctrl_value;
  logic       data_write;
  logic [7:0] data_value;
  logic       rx_valid;
  logic [3:0] rx_index;
  logic [7:0] rx_byte;
  logic       done_res;
  logic       response;
  logic [1:0] error_code;

  modport source (output valid, output ctrl_write, output ctrl_value,
                  output data_write, output data_value, output rx_valid,
                  output rx_index, output rx_byte, output done_res,
                  output response, output error_code, input ready);
  modport sink (input valid, input ctrl_write, input ctrl_value,
                input data_write, input data_value, input rx_valid,
                input rx_index, input rx_byte, input done_res,
                input response, input error_code, output ready);
endinterface

>>> hdl/i2cms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the transmit byte buffer.
module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/i2cms_ctrl.sv
// Controller of the I2C master transfer sequencer: item sequencing and transfer phase.
// Depends on i2cms_pkg; drives the datapath through dp_cmd_t, reads dp_status_t.
module i2cms_ctrl
  import i2cms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  seq_t   seq, seq_next;
  phase_t phase, phase_next;
  logic   commit;

  assign commit = (seq == SEQ_EXEC) && st.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq   <= SEQ_WAIT;
      phase <= PH_IDLE;
    end else begin
      seq   <= seq_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    seq_next = seq;
    case (seq)
      SEQ_WAIT: if (req_valid) seq_next = SEQ_EXEC;
      SEQ_EXEC: if (st.out_free) seq_next = SEQ_WAIT;
      default:  seq_next = SEQ_WAIT;
    endcase
  end

  always_comb begin
    phase_next = phase;
    if (commit) begin
      case (st.kind)
        KIND_START: if (phase == PH_IDLE) phase_next = PH_ADDR;
        KIND_EVENT: begin
          case (phase)
            PH_ADDR: begin
              if (!st.ack_ok) phase_next = PH_IDLE;
              else if (st.read_flag) phase_next = PH_RX;
              else phase_next = PH_TX;
            end
            PH_TX: if (!st.tx_more || st.noack) phase_next = PH_IDLE;
            PH_RX: if (st.rx_last) phase_next = PH_IDLE;
            default: phase_next = phase;
          endcase
        end
        default: phase_next = phase;
      endcase
    end
  end

  always_comb begin
    req_ready      = (seq == SEQ_WAIT);
    cmd            = '0;
    cmd.pos_op     = POS_HOLD;
    cmd.ctrl_sel   = CSEL_NONE;
    cmd.data_sel   = DSEL_NONE;
    cmd.err        = ERR_NONE;
    cmd.capture    = (seq == SEQ_WAIT) && req_valid;
    cmd.commit     = commit;
    case (st.kind)
      KIND_START: begin
        if (phase != PH_IDLE) begin
          cmd.err = ERR_BUSY;
        end else begin
          cmd.ctrl_sel   = CSEL_START_TX;
          cmd.data_sel   = DSEL_ADDR;
          cmd.save_start = 1'b1;
          cmd.pos_op     = POS_CLEAR;
        end
      end
      KIND_EVENT: begin
        case (phase)
          PH_IDLE: cmd.err = ERR_IDLE;
          PH_ADDR: begin
            if (!st.ack_ok) begin
              cmd.ctrl_sel = CSEL_STOP;
              cmd.done     = 1'b1;
              cmd.resp     = 1'b1;
            end else if (st.read_flag) begin
              cmd.ctrl_sel = st.count_one ? CSEL_START_RX_AK : CSEL_START_RX;
            end else begin
              cmd.data_sel = DSEL_BUF;
              cmd.pos_op   = POS_ONE;
            end
          end
          PH_TX: begin
            if (st.tx_more && !st.noack) begin
              cmd.data_sel = DSEL_BUF;
              cmd.pos_op   = POS_INC;
            end else begin
              cmd.ctrl_sel = CSEL_STOP;
              cmd.done     = 1'b1;
              cmd.resp     = st.tx_more;
            end
          end
          default: begin
            if (st.rx_penult) cmd.ctrl_sel = CSEL_TXAK;
            if (st.rx_last) begin
              cmd.ctrl_sel = CSEL_STOP;
              cmd.done     = 1'b1;
            end
            cmd.rx_deliver = 1'b1;
            cmd.pos_op     = POS_INC;
          end
        endcase
      end
      default: cmd.err = ERR_NONE;
    endcase
  end

endmodule

>>> hdl/i2cms_dp.sv
// Datapath of the I2C master transfer sequencer: item, transfer and result registers.
// Depends on i2cms_pkg and i2cms_ram; steered by the controller through dp_cmd_t.
module i2cms_dp
  import i2cms_pkg::*;
#(
  parameter int MAX_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_status_t        st,
  input  logic              cfg_valid,
  input  logic              cfg_int_enable,
  input  logic [1:0]        kind,
  input  logic [IDX_W-1:0]  tx_index,
  input  logic [BYTE_W-1:0] tx_byte,
  input  logic [BYTE_W-1:0] address_byte,
  input  logic [CNT_W-1:0]  byte_count,
  input  logic [BYTE_W-1:0] status_flags,
  input  logic [BYTE_W-1:0] rx_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              ctrl_write,
  output logic [BYTE_W-1:0] ctrl_value,
  output logic              data_write,
  output logic [BYTE_W-1:0] data_value,
  output logic              rx_valid,
  output logic [IDX_W-1:0]  rx_index,
  output logic [BYTE_W-1:0] rx_byte,
  output logic              done_res,
  output logic              response,
  output logic [1:0]        error_code
);

  localparam int AW = $clog2(MAX_BYTES);
  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] CNT_CAP =
    CNT_W'((MAX_BYTES > CNT_MAX) ? CNT_MAX : MAX_BYTES);

  logic                int_enable;
  logic [1:0]          item_kind;
  logic [BYTE_W-1:0]   item_addr;
  logic [CNT_W-1:0]    item_count;
  logic [BYTE_W-1:0]   item_status;
  logic [BYTE_W-1:0]   item_rx;
  logic [CNT_W-1:0]    byte_pos, byte_pos_next;
  logic [BYTE_W-1:0]   saved_address;
  logic [CNT_W-1:0]    saved_count;
  logic [CNT_W-1:0]    count_clamped;
  logic [BYTE_W-1:0]   buf_data;
  logic [BYTE_W-1:0]   ctrl_code;
  logic                buf_we;

  assign buf_we = cmd.capture && (kind == KIND_LOAD) && (32'(tx_index) < MAX_BYTES);

  i2cms_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_BYTES)
  ) u_tx_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (AW'(tx_index)),
    .wdata (tx_byte),
    .raddr (AW'(byte_pos)),
    .rdata (buf_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      int_enable <= 1'b0;
    end else if (cfg_valid) begin
      int_enable <= cfg_int_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_kind <= KIND_LOAD;
    end else if (cmd.capture) begin
      item_kind <= kind;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_addr   <= address_byte;
      item_count  <= byte_count;
      item_status <= status_flags;
      item_rx     <= rx_data;
    end
  end

  always_comb begin
    count_clamped = item_count;
    if (item_count == '0) count_clamped = CNT_W'(1);
    if (item_count > CNT_CAP) count_clamped = CNT_CAP;
  end

  always_comb begin
    case (cmd.pos_op)
      POS_CLEAR: byte_pos_next = '0;
      POS_ONE:   byte_pos_next = CNT_W'(1);
      POS_INC:   byte_pos_next = byte_pos + CNT_W'(1);
      default:   byte_pos_next = byte_pos;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos      <= '0;
      saved_address <= '0;
      saved_count   <= '0;
    end else if (cmd.commit) begin
      byte_pos <= byte_pos_next;
      if (cmd.save_start) begin
        saved_address <= item_addr;
        saved_count   <= count_clamped;
      end
    end
  end

  always_comb begin
    st.kind      = item_kind;
    st.ack_ok    = (item_status & (ST_NOACK | ST_ARBL)) == '0;
    st.noack     = (item_status & ST_NOACK) != '0;
    st.read_flag = saved_address[0];
    st.count_one = (saved_count == CNT_W'(1));
    st.tx_more   = (byte_pos < saved_count);
    st.rx_penult = ({1'b0, byte_pos} + (CNT_W+1)'(2)) == {1'b0, saved_count};
    st.rx_last   = ({1'b0, byte_pos} + (CNT_W+1)'(1)) == {1'b0, saved_count};
    st.out_free  = !out_valid || out_ready;
  end

  always_comb begin
    case (cmd.ctrl_sel)
      CSEL_START_TX:    ctrl_code = CTL_START_TX;
      CSEL_START_RX:    ctrl_code = CTL_START_RX;
      CSEL_START_RX_AK: ctrl_code = CTL_START_RX | CTL_TXAK;
      CSEL_TXAK:        ctrl_code = CTL_TXAK;
      CSEL_STOP:        ctrl_code = CTL_STOP;
      default:          ctrl_code = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ctrl_write <= (cmd.ctrl_sel != CSEL_NONE);
      ctrl_value <= (cmd.ctrl_sel == CSEL_NONE) ? '0 :
                    (ctrl_code | (int_enable ? CTL_IE : '0));
      data_write <= (cmd.data_sel != DSEL_NONE);
      case (cmd.data_sel)
        DSEL_ADDR: data_value <= item_addr;
        DSEL_BUF:  data_value <= buf_data;
        default:   data_value <= '0;
      endcase
      rx_valid   <= cmd.rx_deliver;
      rx_index   <= cmd.rx_deliver ? byte_pos[IDX_W-1:0] : '0;
      rx_byte    <= cmd.rx_deliver ? item_rx : '0;
      done_res   <= cmd.done;
      response   <= cmd.resp;
      error_code <= cmd.err;
    end
  end

endmodule

>>> hdl/i2c_master_transfer_sequencer_core.sv
// I2C master transfer sequencer, top level: one result beat per accepted item.
// An accepted item is registered; its result then enters the output register.
// No new item is taken until the result of the last one is committed; the item
// waits in execute while the result is stalled.
// Reset clears phase to idle, byte position, saved transfer and interrupt enable;
// transmit buffer contents are undefined until loaded.
module i2c_master_transfer_sequencer_core
  import i2cms_pkg::*;
#(
  parameter int MAX_BYTES = 16
) (
  input logic         clk,
  input logic         rst,
  i2cms_cfg_if.sink   cfg,
  i2cms_req_if.sink   req,
  i2cms_rsp_if.source rsp
);

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       req_ready;

  assign cfg.ready = 1'b1;
  assign req.ready = req_ready;

  i2cms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  i2cms_dp #(
    .MAX_BYTES (MAX_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_valid      (cfg.valid),
    .cfg_int_enable (cfg.int_enable),
    .kind           (req.kind),
    .tx_index       (req.tx_index),
    .tx_byte        (req.tx_byte),
    .address_byte   (req.address_byte),
    .byte_count     (req.byte_count),
    .status_flags   (req.status_flags),
    .rx_data        (req.rx_data),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .ctrl_write     (rsp.ctrl_write),
    .ctrl_value     (rsp.ctrl_value),
    .data_write     (rsp.data_write),
    .data_value     (rsp.data_value),
    .rx_valid       (rsp.rx_valid),
    .rx_index       (rsp.rx_index),
    .rx_byte        (rsp.rx_byte),
    .done_res       (rsp.done_res),
    .response       (rsp.response),
    .error_code     (rsp.error_code)
  );

endmodule

>>> tb/sv/tb_i2c_master_transfer_sequencer_core.sv
// Testbench for the I2C master transfer sequencer core: directed table, then
// random transfer sequences under several idling phases, scored by a predictor.
// Depends on i2cms_pkg and the cfg, req and rsp channel interfaces.
module tb_i2c_master_transfer_sequencer_core;
  import i2cms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BYTES = 16;
  localparam int DIR_ROWS = 25;
  localparam int RANDOM_ITEMS = 130;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int SEND_IDLE_PCT [4] = '{0, 80, 0, 8};
  localparam int STALL_PCT [4] = '{0, 0, 80, 8};

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] tx_index;
    logic [7:0] tx_byte;
    logic [7:0] address_byte;
    logic [4:0] byte_count;
    logic [7:0] status_flags;
    logic [7:0] rx_data;
  } req_t;

  typedef struct packed {
    logic       ctrl_write;
    logic [7:0] ctrl_value;
    logic       data_write;
    logic [7:0] data_value;
    logic       rx_valid;
    logic [3:0] rx_index;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       response;
    logic [1:0] error_code;
  } rsp_t;

  typedef struct packed {
    req_t item;
    logic pinned;
    rsp_t want;
  } dir_row_t;

  localparam rsp_t NO_BEAT = '0;
  localparam rsp_t IDLE_ERR_BEAT =
    '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 4'd0, 8'h00, 1'b0, 1'b0, ERR_IDLE};
  localparam rsp_t BUSY_ERR_BEAT =
    '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 4'd0, 8'h00, 1'b0, 1'b0, ERR_BUSY};
  localparam rsp_t STOP_OK_BEAT =
    '{1'b1, CTL_STOP, 1'b0, 8'h00, 1'b0, 4'd0, 8'h00, 1'b1, 1'b0, ERR_NONE};
  localparam rsp_t STOP_NORESP_BEAT =
    '{1'b1, CTL_STOP, 1'b0, 8'h00, 1'b0, 4'd0, 8'h00, 1'b1, 1'b1, ERR_NONE};

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{'{KIND_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 8'h00, 8'h00}, 1'b1, IDLE_ERR_BEAT},
    '{'{KIND_UNUSED, 4'd15, 8'hff, 8'hff, 5'd31, 8'hff, 8'hff}, 1'b1, NO_BEAT},
    '{'{KIND_LOAD, 4'd0, 8'h00, 8'h00, 5'd0, 8'h00, 8'h00}, 1'b1, NO_BEAT},
    '{'{KIND_LOAD, 4'd1, 8'hff, 8'h00, 5'd0, 8'h00, 8'h00}, 1'b1, NO_BEAT},
    '{'{KIND_LOAD, 4'd15, 8'h5a, 8'h00, 5'd0, 8'h00, 8'h00}, 1'b1, NO_BEAT},
    '{'{KIND_START, 4'd0, 8'h00, 8'h00, 5'd2, 8'h00, 8'h00}, 1'b1,
      '{1'b1, CTL_START_TX, 1'b1, 8'h00, 1'b0, 4'd0, 8'h00, 1'b0, 1'b0, ERR_NONE}},
    '{'{KIND_START, 4'd0, 8'h00, 8'h81, 5'd5, 8'h00, 8'h00}, 1'b1, BUSY_ERR_BEAT},
    '{'{KIND_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 8'h00, 8'h00}, 1'b0, NO_BEAT},
    '{'{KIND_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 8'h00, 8'h00}, 1'b0, NO_BEAT},
    '{'{KIND_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 8'hee, 8'h00}, 1'b1, STOP_OK_BEAT},
    '{'{KIND_START, 4'd0, 8'h00, 8'hff, 5'd0, 8'h00, 8'h00}, 1'b1,
      '{1'b1, CTL_START_TX, 1'b1, 8'hff, 1'b0, 4'd0, 8'h00, 1'b0, 1'b0, ERR_NONE}},
    '{'{KIND_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 8'h00, 8'h00}, 1'b0, NO_BEAT},
    '{'{KIND_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 8'h00, 8'hff}, 1'b0, NO_BEAT},
    '{'{KIND_START, 4'd0, 8'h00, 8'h01, 5'd31, 8'h00, 8'h00}, 1'b1,
      '{1'b1, CTL_START_TX, 1'b1, 8'h01, 1'b0, 4'd0, 8'h00, 1'b0, 1'b0, ERR_NONE}},
    '{'{KIND_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, ST_NOACK, 8'h00}, 1'b1, STOP_NORESP_BEAT},
    '{'{KIND_START, 4'd0, 8'h00, 8'h03, 5'd3, 8'h00, 8'h00}, 1'b1,
      '{1'b1, CTL_START_TX, 1'b1, 8'h03, 1'b0, 4'd0, 8'h00, 1'b0, 1'b0, ERR_NONE}},
    '{'{KIND_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, ST_ARBL, 8'h00}, 1'b1, STOP_NORESP_BEAT},
    '{'{KIND_START, 4'd0, 8'h00, 8'hfe, 5'd2, 8'h00, 8'h00}, 1'b1,
      '{1'b1, CTL_START_TX, 1'b1, 8'hfe, 1'b0, 4'd0, 8'h00, 1'b0, 1'b0, ERR_NONE}},
    '{'{KIND_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 8'hee, 8'h00}, 1'b0, NO_BEAT},
    '{'{KIND_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 8'hff, 8'h00}, 1'b1, STOP_NORESP_BEAT},
    '{'{KIND_START, 4'd0, 8'h00, 8'h05, 5'd3, 8'h00, 8'h00}, 1'b1,
      '{1'b1, CTL_START_TX, 1'b1, 8'h05, 1'b0, 4'd0, 8'h00, 1'b0, 1'b0, ERR_NONE}},
    '{'{KIND_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 8'h00, 8'h00}, 1'b0, NO_BEAT},
    '{'{KIND_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 8'h00, 8'h00}, 1'b0, NO_BEAT},
    '{'{KIND_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 8'h11, 8'ha5}, 1'b0, NO_BEAT},
    '{'{KIND_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 8'h00, 8'h5a}, 1'b0, NO_BEAT}
  };

  string field_names [10] = '{"ctrl_write", "ctrl_value", "data_write", "data_value",
                              "rx_valid", "rx_index", "rx_byte", "done_res",
                              "response", "error_code"};

  logic clk = 1'b0;
  logic rst;

  i2cms_cfg_if cfg_if ();
  i2cms_req_if req_if ();
  i2cms_rsp_if rsp_if ();

  i2c_master_transfer_sequencer_core #(
    .MAX_BYTES(MAX_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_if),
    .req(req_if),
    .rsp(rsp_if)
  );

  always #6 clk = ~clk;

  phase_t     seq_phase = PH_IDLE;
  logic [4:0] seq_pos = '0;
  logic [7:0] seq_addr = '0;
  logic [4:0] seq_count = '0;
  logic [7:0] tx_mem [MAX_BYTES];
  logic       ie_reg = 1'b0;

  rsp_t pending_beats [$];
  logic cur_pinned;
  rsp_t cur_want;
  logic [MAX_BYTES-1:0] tx_loaded = '0;
  int items_sent = 0;
  int items_accepted = 0;
  int beats_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic rsp_t sequencer_response(req_t it);
    rsp_t r;
    logic [4:0] cnt;
    logic [7:0] ie;
    r = NO_BEAT;
    cnt = it.byte_count;
    ie = ie_reg ? CTL_IE : 8'h00;
    case (it.kind)
      KIND_LOAD: tx_mem[it.tx_index] = it.tx_byte;
      KIND_START: begin
        if (seq_phase != PH_IDLE) begin
          r.error_code = ERR_BUSY;
        end else begin
          if (cnt == 0) cnt = 5'd1;
          if (cnt > MAX_BYTES) cnt = 5'(MAX_BYTES);
          seq_phase = PH_ADDR;
          seq_pos = '0;
          seq_addr = it.address_byte;
          seq_count = cnt;
          r.ctrl_write = 1'b1;
          r.ctrl_value = CTL_START_TX | ie;
          r.data_write = 1'b1;
          r.data_value = it.address_byte;
        end
      end
      KIND_EVENT: begin
        case (seq_phase)
          PH_IDLE: r.error_code = ERR_IDLE;
          PH_ADDR: begin
            if ((it.status_flags & (ST_NOACK | ST_ARBL)) == 0) begin
              if (seq_addr[0]) begin
                r.ctrl_write = 1'b1;
                r.ctrl_value = ((seq_count == 1) ? (CTL_START_RX | CTL_TXAK) : CTL_START_RX)
                               | ie;
                seq_phase = PH_RX;
              end else begin
                r.data_write = 1'b1;
                r.data_value = tx_mem[0];
                seq_phase = PH_TX;
                seq_pos = 5'd1;
              end
            end else begin
              r.ctrl_write = 1'b1;
              r.ctrl_value = CTL_STOP | ie;
              r.done_res = 1'b1;
              r.response = 1'b1;
              seq_phase = PH_IDLE;
            end
          end
          PH_TX: begin
            if (seq_pos < seq_count) begin
              if ((it.status_flags & ST_NOACK) == 0) begin
                r.data_write = 1'b1;
                r.data_value = tx_mem[seq_pos[3:0]];
                seq_pos = seq_pos + 5'd1;
              end else begin
                r.done_res = 1'b1;
                r.response = 1'b1;
              end
            end else begin
              r.done_res = 1'b1;
            end
            if (r.done_res) begin
              r.ctrl_write = 1'b1;
              r.ctrl_value = CTL_STOP | ie;
              seq_phase = PH_IDLE;
            end
          end
          default: begin
            if (int'(seq_pos) + 2 == int'(seq_count)) begin
              r.ctrl_write = 1'b1;
              r.ctrl_value = CTL_TXAK | ie;
            end
            if (int'(seq_pos) + 1 == int'(seq_count)) begin
              r.ctrl_write = 1'b1;
              r.ctrl_value = CTL_STOP | ie;
              r.done_res = 1'b1;
              seq_phase = PH_IDLE;
            end
            r.rx_valid = 1'b1;
            r.rx_index = seq_pos[3:0];
            r.rx_byte = it.rx_data;
            seq_pos = seq_pos + 5'd1;
          end
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int field_value(rsp_t r, int f);
    case (f)
      0: return r.ctrl_write;
      1: return r.ctrl_value;
      2: return r.data_write;
      3: return r.data_value;
      4: return r.rx_valid;
      5: return r.rx_index;
      6: return r.rx_byte;
      7: return r.done_res;
      8: return r.response;
      default: return r.error_code;
    endcase
  endfunction

  function automatic req_t random_item();
    req_t it;
    it.kind = 2'($urandom_range(0, 3));
    it.tx_index = 4'($urandom_range(0, 15));
    it.tx_byte = 8'($urandom_range(0, 255));
    it.address_byte = 8'($urandom_range(0, 255));
    it.byte_count = 5'($urandom_range(0, 31));
    it.status_flags = 8'($urandom_range(0, 255));
    it.rx_data = 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic put_item(req_t it, logic pinned, rsp_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.kind <= it.kind;
    req_if.tx_index <= it.tx_index;
    req_if.tx_byte <= it.tx_byte;
    req_if.address_byte <= it.address_byte;
    req_if.byte_count <= it.byte_count;
    req_if.status_flags <= it.status_flags;
    req_if.rx_data <= it.rx_data;
    cur_pinned <= pinned;
    cur_want <= want;
    if (it.kind == KIND_LOAD) tx_loaded[it.tx_index] = 1'b1;
    if (it.kind != KIND_UNUSED) items_sent++;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    items_accepted++;
  endtask

  task automatic write_int_enable(logic value);
    req_if.valid <= 1'b0;
    while (beats_seen < items_accepted) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.int_enable <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_transfer();
    req_t start, ld, ev;
    logic rd;
    int n;
    int pick;
    rd = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    n = $urandom_range(1, MAX_BYTES);
    start = random_item();
    start.kind = KIND_START;
    start.address_byte[0] = rd;
    if (pick == 0) begin
      n = 1;
      start.byte_count = 5'd0;
    end else if (pick == 1) begin
      n = MAX_BYTES;
      start.byte_count = 5'($urandom_range(MAX_BYTES, 31));
    end else begin
      start.byte_count = 5'(n);
    end
    if (!rd) begin
      for (int i = 0; i < n; i++) begin
        if (!tx_loaded[i] || $urandom_range(0, 1)) begin
          ld = random_item();
          ld.kind = KIND_LOAD;
          ld.tx_index = 4'(i);
          put_item(ld, 1'b0, NO_BEAT);
        end
      end
    end
    put_item(start, 1'b0, NO_BEAT);
    ev = random_item();
    ev.kind = KIND_EVENT;
    if ($urandom_range(0, 9) != 0) ev.status_flags &= ~(ST_NOACK | ST_ARBL);
    put_item(ev, 1'b0, NO_BEAT);
    if ((ev.status_flags & (ST_NOACK | ST_ARBL)) != 0) return;
    for (int i = 1; i <= n; i++) begin
      ev = random_item();
      ev.kind = KIND_EVENT;
      if (!rd && $urandom_range(0, 9) != 0) ev.status_flags &= ~ST_NOACK;
      put_item(ev, 1'b0, NO_BEAT);
      if (!rd && i < n && ev.status_flags[0]) return;
    end
  endtask

  task automatic run_random(int quota);
    req_t it;
    int first;
    int eff;
    first = items_sent;
    while (items_sent - first < quota) begin
      if ($urandom_range(0, 4) != 0) begin
        run_transfer();
      end else begin
        it = random_item();
        eff = (it.byte_count == 0) ? 1 : (it.byte_count > MAX_BYTES) ? MAX_BYTES
                                                                      : it.byte_count;
        if (it.kind == KIND_START && !it.address_byte[0]) begin
          for (int i = 0; i < eff; i++) if (!tx_loaded[i]) it.address_byte[0] = 1'b1;
        end
        put_item(it, 1'b0, NO_BEAT);
      end
    end
  endtask

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : score
    req_t seen_item;
    rsp_t got_beat;
    rsp_t due_beat;
    logic progress;
    if (!rst) begin
      progress = 1'b0;
      if (cfg_if.valid && cfg_if.ready) begin
        ie_reg = cfg_if.int_enable;
        progress = 1'b1;
      end
      if (req_if.valid && req_if.ready) begin
        seen_item = '{req_if.kind, req_if.tx_index, req_if.tx_byte, req_if.address_byte,
                      req_if.byte_count, req_if.status_flags, req_if.rx_data};
        due_beat = sequencer_response(seen_item);
        if (cur_pinned) due_beat = cur_want;
        pending_beats.push_back(due_beat);
        progress = 1'b1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got_beat = '{rsp_if.ctrl_write, rsp_if.ctrl_value, rsp_if.data_write,
                     rsp_if.data_value, rsp_if.rx_valid, rsp_if.rx_index, rsp_if.rx_byte,
                     rsp_if.done_res, rsp_if.response, rsp_if.error_code};
        beats_seen++;
        progress = 1'b1;
        if (pending_beats.size() == 0) begin
          $display("%0t unexpected beat: expected none, actual %h", $time, got_beat);
          mismatches++;
        end else begin
          due_beat = pending_beats.pop_front();
          for (int f = 0; f < 10; f++) begin
            if (field_value(due_beat, f) != field_value(got_beat, f)) begin
              $display("%0t %s: expected %0h, actual %0h", $time, field_names[f],
                       field_value(due_beat, f), field_value(got_beat, f));
              mismatches++;
            end
          end
        end
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_if.valid <= 1'b0;
    cfg_if.int_enable <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.kind <= KIND_LOAD;
    req_if.tx_index <= '0;
    req_if.tx_byte <= '0;
    req_if.address_byte <= '0;
    req_if.byte_count <= '0;
    req_if.status_flags <= '0;
    req_if.rx_data <= '0;
    cur_pinned <= 1'b0;
    cur_want <= NO_BEAT;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_int_enable(1'b0);
    for (int i = 0; i < DIR_ROWS; i++)
      put_item(DIRECTED[i].item, DIRECTED[i].pinned, DIRECTED[i].want);
    for (int m = 0; m < 4; m++) begin
      write_int_enable(~m[0]);
      send_idle_pct = SEND_IDLE_PCT[m];
      stall_pct = STALL_PCT[m];
      run_random(RANDOM_ITEMS);
    end
    // hold the receiver off while the sender keeps offering items
    write_int_enable(1'b1);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_asks++;
    run_random(RANDOM_ITEMS);
    req_if.valid <= 1'b0;
    while (beats_seen < items_accepted) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_beats.size() != 0) begin
      $display("%0t %0d expected beats never arrived, actual none", $time,
               pending_beats.size());
      mismatches++;
    end
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
